>>> hw/rtl/nnsag_pkg.sv
// Shared types, constants and helper functions for the nearest-neighbour
// scaler address generator. No dependencies.
`timescale 1ns / 1ps

package nnsag_pkg;

  localparam int COORD_BITS    = 12;
  localparam int STEP_BITS     = COORD_BITS + 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  // Register indices, as found at paddr[4:2].
  typedef enum logic [2:0] {
    REG_TARGET_WIDTH  = 3'd0,
    REG_TARGET_HEIGHT = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } reg_idx_t;

  localparam coord_t RST_TARGET_WIDTH  = coord_t'(1160);
  localparam coord_t RST_TARGET_HEIGHT = coord_t'(688);
  localparam coord_t RST_SOURCE_WIDTH  = coord_t'(768);
  localparam coord_t RST_SOURCE_HEIGHT = coord_t'(512);
  localparam coord_t RST_SCREEN_WIDTH  = coord_t'(1280);
  localparam coord_t RST_SCREEN_HEIGHT = coord_t'(720);

  // Per-axis plan: clipped target size, centring offset, step count and
  // source size.
  typedef struct packed {
    coord_t eff;
    coord_t off;
    coord_t steps;
    coord_t src;
  } axis_plan_t;

  // Current position of one axis, as shown on the result channel.
  typedef struct packed {
    logic   last;
    coord_t dest;
    coord_t src;
  } axis_pos_t;

  typedef struct packed {
    step_t  acc;
    coord_t cur;
  } dda_t;

  function automatic axis_plan_t plan_axis(coord_t tgt, coord_t src, coord_t scr);
    axis_plan_t p;
    coord_t     t;
    coord_t     n;
    coord_t     diff;
    diff = scr - tgt;
    if (tgt > scr) begin
      t     = scr;
      p.off = '0;
    end else begin
      t     = tgt;
      p.off = {1'b0, diff[COORD_BITS-1:1]};
    end
    n = (t > src) ? t : src;
    if (n == '0) begin
      n = coord_t'(1);
    end
    p.eff   = t;
    p.steps = n;
    p.src   = src;
    return p;
  endfunction

  // One DDA step: add the size and, at or past the step count, take it off
  // again and move the coordinate on by one.
  function automatic dda_t dda_step(step_t acc, coord_t cur, coord_t size, coord_t steps);
    dda_t  d;
    step_t a;
    a = acc + {1'b0, size};
    if (a >= {1'b0, steps}) begin
      d.acc = a - {1'b0, steps};
      d.cur = cur + coord_t'(1);
    end else begin
      d.acc = a;
      d.cur = cur;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/nnsag_cfg.sv
// APB-style register file for the window geometry, with the registered
// per-axis plan derived from it. Depends on nnsag_pkg.
`timescale 1ns / 1ps

module nnsag_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nnsag_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [nnsag_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [nnsag_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                cfg_pready,
  output nnsag_pkg::axis_plan_t               plan_x,
  output nnsag_pkg::axis_plan_t               plan_y
);
  import nnsag_pkg::*;

  coord_t     tgt_w_r, tgt_h_r, src_w_r, src_h_r, scr_w_r, scr_h_r;
  coord_t     tgt_w_nxt, tgt_h_nxt, src_w_nxt, src_h_nxt, scr_w_nxt, scr_h_nxt;
  axis_plan_t plan_x_r, plan_y_r;
  logic       wr_en;
  logic [2:0] idx;
  coord_t     wdata;
  coord_t     rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign wdata      = cfg_pwdata[COORD_BITS-1:0];

  always_comb begin
    tgt_w_nxt = tgt_w_r;
    tgt_h_nxt = tgt_h_r;
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    if (wr_en) begin
      case (idx)
        REG_TARGET_WIDTH:  tgt_w_nxt = wdata;
        REG_TARGET_HEIGHT: tgt_h_nxt = wdata;
        REG_SOURCE_WIDTH:  src_w_nxt = wdata;
        REG_SOURCE_HEIGHT: src_h_nxt = wdata;
        REG_SCREEN_WIDTH:  scr_w_nxt = wdata;
        REG_SCREEN_HEIGHT: scr_h_nxt = wdata;
        default: ;
      endcase
    end
  end

  // The plan is worked out from the incoming values, so it is ready in the
  // same cycle as the registers themselves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_w_r  <= RST_TARGET_WIDTH;
      tgt_h_r  <= RST_TARGET_HEIGHT;
      src_w_r  <= RST_SOURCE_WIDTH;
      src_h_r  <= RST_SOURCE_HEIGHT;
      scr_w_r  <= RST_SCREEN_WIDTH;
      scr_h_r  <= RST_SCREEN_HEIGHT;
      plan_x_r <= plan_axis(RST_TARGET_WIDTH, RST_SOURCE_WIDTH, RST_SCREEN_WIDTH);
      plan_y_r <= plan_axis(RST_TARGET_HEIGHT, RST_SOURCE_HEIGHT, RST_SCREEN_HEIGHT);
    end else begin
      tgt_w_r  <= tgt_w_nxt;
      tgt_h_r  <= tgt_h_nxt;
      src_w_r  <= src_w_nxt;
      src_h_r  <= src_h_nxt;
      scr_w_r  <= scr_w_nxt;
      scr_h_r  <= scr_h_nxt;
      plan_x_r <= plan_axis(tgt_w_nxt, src_w_nxt, scr_w_nxt);
      plan_y_r <= plan_axis(tgt_h_nxt, src_h_nxt, scr_h_nxt);
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_WIDTH:  rdata = tgt_w_r;
      REG_TARGET_HEIGHT: rdata = tgt_h_r;
      REG_SOURCE_WIDTH:  rdata = src_w_r;
      REG_SOURCE_HEIGHT: rdata = src_h_r;
      REG_SCREEN_WIDTH:  rdata = scr_w_r;
      REG_SCREEN_HEIGHT: rdata = scr_h_r;
      default:           rdata = '0;
    endcase
  end

  assign cfg_prdata = {{(CFG_DATA_BITS-COORD_BITS){1'b0}}, rdata};
  assign plan_x     = plan_x_r;
  assign plan_y     = plan_y_r;

endmodule

>>> hw/rtl/nnsag_axis.sv
// One axis of the address generator: step counter and the destination and
// source DDA accumulators. Depends on nnsag_pkg.
`timescale 1ns / 1ps

module nnsag_axis (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  restart,
  input  logic                  gate,
  input  nnsag_pkg::axis_plan_t plan,
  output nnsag_pkg::axis_pos_t  pos
);
  import nnsag_pkg::*;

  step_t  step_r, acc_dst_r, acc_src_r;
  coord_t cur_dst_r, cur_src_r;
  step_t  step_nxt, acc_dst_nxt, acc_src_nxt;
  coord_t cur_dst_nxt, cur_src_nxt;
  step_t  step_e, acc_dst_e, acc_src_e;
  coord_t cur_dst_e, cur_src_e;
  coord_t last_step;
  logic   last;
  dda_t   dda_dst, dda_src;

  // A restart clears the axis before the request is worked on.
  assign step_e    = restart ? '0 : step_r;
  assign acc_dst_e = restart ? '0 : acc_dst_r;
  assign acc_src_e = restart ? '0 : acc_src_r;
  assign cur_dst_e = restart ? '0 : cur_dst_r;
  assign cur_src_e = restart ? '0 : cur_src_r;

  assign last_step = plan.steps - coord_t'(1);
  assign last      = step_e >= {1'b0, last_step};

  assign dda_dst = dda_step(acc_dst_e, cur_dst_e, plan.eff, plan.steps);
  assign dda_src = dda_step(acc_src_e, cur_src_e, plan.src, plan.steps);

  always_comb begin
    step_nxt    = step_r;
    acc_dst_nxt = acc_dst_r;
    acc_src_nxt = acc_src_r;
    cur_dst_nxt = cur_dst_r;
    cur_src_nxt = cur_src_r;
    if (step_en) begin
      if (gate && !last) begin
        step_nxt    = step_e + step_t'(1);
        acc_dst_nxt = dda_dst.acc;
        acc_src_nxt = dda_src.acc;
        cur_dst_nxt = dda_dst.cur;
        cur_src_nxt = dda_src.cur;
      end else if (gate) begin
        step_nxt    = '0;
        acc_dst_nxt = '0;
        acc_src_nxt = '0;
        cur_dst_nxt = '0;
        cur_src_nxt = '0;
      end else begin
        step_nxt    = step_e;
        acc_dst_nxt = acc_dst_e;
        acc_src_nxt = acc_src_e;
        cur_dst_nxt = cur_dst_e;
        cur_src_nxt = cur_src_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      acc_dst_r <= '0;
      acc_src_r <= '0;
      cur_dst_r <= '0;
      cur_src_r <= '0;
    end else begin
      step_r    <= step_nxt;
      acc_dst_r <= acc_dst_nxt;
      acc_src_r <= acc_src_nxt;
      cur_dst_r <= cur_dst_nxt;
      cur_src_r <= cur_src_nxt;
    end
  end

  assign pos.last = last;
  assign pos.dest = plan.off + cur_dst_e;
  assign pos.src  = cur_src_e;

endmodule

>>> hw/rtl/nearest_neighbor_scale_addr_gen.sv
// Nearest-neighbour scaler address generator: top level with the column and
// row axes and the result register. Depends on nnsag_pkg, nnsag_cfg, nnsag_axis.
// An accepted request's result is registered and shown on the out_ channel in the next cycle.
// Throughput: one request per cycle while out_ready is high; the result register is refilled in the cycle it empties.
// Reset (rst_n, synchronous) clears all counters and accumulators and loads the
// default geometry; the block accepts requests in the first cycle after reset.
`timescale 1ns / 1ps

module nearest_neighbor_scale_addr_gen (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nnsag_pkg::COORD_BITS-1:0]    out_dest_x,
  output logic [nnsag_pkg::COORD_BITS-1:0]    out_dest_y,
  output logic [nnsag_pkg::COORD_BITS-1:0]    out_src_x,
  output logic [nnsag_pkg::COORD_BITS-1:0]    out_src_y,
  output logic                                out_row_end,
  output logic                                out_frame_end,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nnsag_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [nnsag_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [nnsag_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import nnsag_pkg::*;

  axis_plan_t plan_x, plan_y;
  axis_pos_t  pos_x, pos_y;
  logic       in_acc;
  logic       out_valid_r;
  coord_t     dest_x_r, dest_y_r, src_x_r, src_y_r;
  logic       row_end_r, frame_end_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  nnsag_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .plan_x      (plan_x),
    .plan_y      (plan_y)
  );

  // Columns step on every request; rows only when the column wraps.
  nnsag_axis u_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .restart (in_restart),
    .gate    (1'b1),
    .plan    (plan_x),
    .pos     (pos_x)
  );

  nnsag_axis u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .restart (in_restart),
    .gate    (pos_x.last),
    .plan    (plan_y),
    .pos     (pos_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dest_x_r    <= pos_x.dest;
      dest_y_r    <= pos_y.dest;
      src_x_r     <= pos_x.src;
      src_y_r     <= pos_y.src;
      row_end_r   <= pos_x.last;
      frame_end_r <= pos_x.last && pos_y.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dest_x    = dest_x_r;
  assign out_dest_y    = dest_y_r;
  assign out_src_x     = src_x_r;
  assign out_src_y     = src_y_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted request produced no result");

  a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> out_src_x == '0 && out_src_y == '0)
    else $error("restart did not start at the source origin");

  a_restart_dest_offset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> out_dest_x == $past(plan_x.off)
                              && out_dest_y == $past(plan_y.off))
    else $error("restart did not start at the window offset");

endmodule
